[rtl/bll_pkg.sv]
package bll_pkg;

    localparam int unsigned NodeCountDef = 1024;
    localparam int unsigned LevelsDef    = 10;
    localparam int unsigned NodeW        = 10;
    localparam int unsigned DistW        = 11;
    localparam logic [NodeW-1:0] DepthMax = '1;

    // Item modes.
    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_LCA    = 3'd1,
        MODE_KTH    = 3'd2,
        MODE_DIST   = 3'd3,
        MODE_ROOTED = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]       mode;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
        logic [NodeW-1:0] node_c;
        logic [NodeW-1:0] step_count;
    } t_in_item;

    typedef struct packed {
        logic [NodeW-1:0] result_node;
        logic [DistW-1:0] distance;
        logic             found;
    } t_out_item;

    // Sequencer states. Every read state issues one RAM read; the following
    // state sees the registered data.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD_DEPTH,   // read parent depth
        S_ADD_WR_DEPTH,   // write depth and level 0
        S_ADD_RD_ANC,     // read anc(prev, lvl-1)
        S_ADD_WR_ANC,     // write level lvl
        S_L_START,        // begin one lca walk
        S_L_RD_DA,
        S_L_RD_DB,
        S_L_CMP,
        S_C_RD,           // climb: read anc(x, lvl)
        S_C_WAIT,
        S_J_RD_A,         // joint lift: read anc(a, j)
        S_J_RD_B,
        S_J_WAIT,
        S_J_FIN_RD,
        S_J_FIN_WAIT,
        S_L_DONE,
        S_D_RD,           // distance: three depth reads
        S_D_WAIT,
        S_D_CALC,
        S_OUT
    } t_state;

endpackage

[rtl/bll_ram.sv]
module bll_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/binary_lifting_lca_engine_top.sv]
// One item at a time: busy is high from acceptance to the result, and the next beat is
// taken in the idle cycle after it. An ignored item (an add of node none or an unused mode)
// goes straight to the result strobe.
// Reset (synchronous, active low) returns the sequencer to idle; the tables
// are not cleared. The receiver cannot stall: o_done strobes for one cycle.
module binary_lifting_lca_engine_top
    import bll_pkg::*;
#(
    parameter int unsigned NODE_COUNT = NodeCountDef,
    parameter int unsigned LEVELS     = LevelsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_item
);

    localparam int unsigned SlotW = $clog2(NODE_COUNT);
    localparam int unsigned LvlW  = $clog2(LEVELS);
    localparam int unsigned AncD  = NODE_COUNT * LEVELS;
    localparam int unsigned AncW  = $clog2(AncD);
    localparam logic [LvlW-1:0] LvlLast = LvlW'(LEVELS - 1);

    t_state r_state, n_state;

    // Item registers and walk registers.
    t_in_item         r_in;
    logic [NodeW-1:0] r_a, r_b;          // walk operands
    logic [NodeW-1:0] r_da;              // depth of the first walk node
    logic [NodeW-1:0] r_pa;              // first lift read
    logic [NodeW-1:0] r_x;               // node being climbed
    logic [NodeW-1:0] r_k;               // remaining climb count
    logic [LvlW-1:0]  r_lvl;
    logic [1:0]       r_walk;            // which walk in rooted mode
    logic [NodeW-1:0] r_l0, r_l1, r_res; // walk results
    logic [DistW-1:0] r_dist;
    logic [1:0]       r_dcnt;
    logic [DistW+1:0] r_dsum;
    logic             r_kth;             // climb belongs to kth mode

    logic             anc_we, dep_we;
    logic [AncW-1:0]  anc_waddr, anc_raddr;
    logic [SlotW-1:0] dep_waddr, dep_raddr;
    logic [NodeW-1:0] anc_wdata, dep_wdata, anc_rdata, dep_rdata;

    bll_ram #(.WIDTH(NodeW), .DEPTH(AncD)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_waddr(anc_waddr), .i_wdata(anc_wdata),
        .i_raddr(anc_raddr), .o_rdata(anc_rdata)
    );

    bll_ram #(.WIDTH(NodeW), .DEPTH(NODE_COUNT)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr(dep_raddr), .o_rdata(dep_rdata)
    );

    // Table slot of node n; NODE_COUNT is a power of two, so node ids wrap by truncation.
    function automatic logic [SlotW-1:0] slot_of(input logic [NodeW-1:0] n);
        slot_of = SlotW'({{SlotW{1'b0}}, n});
    endfunction

    // Flat ancestor address of node n at level l.
    function automatic logic [AncW-1:0] anc_addr(input logic [NodeW-1:0] n,
                                                 input logic [LvlW-1:0] l);
        logic [AncW+NodeW:0] s;
        logic [SlotW-1:0]    sl;
        begin
            sl = slot_of(n);
            s  = (AncW+NodeW+1)'(sl) * (AncW+NodeW+1)'(LEVELS) + (AncW+NodeW+1)'(l);
            anc_addr = AncW'(s);
        end
    endfunction

    // Operands of the current lca walk.
    logic [NodeW-1:0] wa, wb;
    always_comb begin
        unique case (r_walk)
            2'd0:    begin wa = r_in.node_a; wb = r_in.node_b; end
            2'd1:    begin wa = r_in.node_a; wb = r_in.node_c; end
            default: begin wa = r_in.node_c; wb = r_in.node_b; end
        endcase
    end

    logic is_rooted, root_done;
    assign is_rooted = (r_in.mode == MODE_ROOTED);
    assign root_done = (r_walk == 2'd2);

    // Climb step at the current level, and the climbed node at the last level.
    logic [NodeW-1:0] c_step, c_node, pb;
    assign c_step = r_k[0] ? ((r_x == '0) ? '0 : anc_rdata) : r_x;
    // Steps beyond the table reach climb to none.
    assign c_node = ((r_k >> 1) != '0) ? '0 : c_step;
    // Lift read of the second node; node none has no ancestors.
    assign pb     = (r_b == '0) ? '0 : anc_rdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) begin
                unique case (i_item.mode)
                    MODE_ADD:  n_state = (i_item.node_a == '0) ? S_OUT : S_ADD_RD_DEPTH;
                    MODE_LCA, MODE_DIST, MODE_ROOTED: n_state = S_L_START;
                    MODE_KTH:  n_state = S_C_RD;
                    default:   n_state = S_OUT;
                endcase
            end
            S_ADD_RD_DEPTH: n_state = S_ADD_WR_DEPTH;
            S_ADD_WR_DEPTH: n_state = (LEVELS > 1) ? S_ADD_RD_ANC : S_OUT;
            S_ADD_RD_ANC:   n_state = S_ADD_WR_ANC;
            S_ADD_WR_ANC:   n_state = (r_lvl == LvlLast) ? S_OUT : S_ADD_RD_ANC;
            S_L_START:      n_state = (wa == '0 || wb == '0) ? S_L_DONE : S_L_RD_DA;
            S_L_RD_DA:      n_state = S_L_RD_DB;
            S_L_RD_DB:      n_state = S_L_CMP;
            S_L_CMP:        n_state = S_C_RD;
            S_C_RD:         n_state = S_C_WAIT;
            S_C_WAIT: begin
                if (r_lvl == LvlLast) begin
                    if (r_kth) n_state = S_OUT;
                    else if (c_node == '0 || c_node == r_a) n_state = S_L_DONE;
                    else n_state = S_J_RD_A;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_J_RD_A:       n_state = S_J_RD_B;
            S_J_RD_B:       n_state = S_J_WAIT;
            S_J_WAIT:       n_state = (r_lvl == '0) ? S_J_FIN_RD : S_J_RD_A;
            S_J_FIN_RD:     n_state = S_J_FIN_WAIT;
            S_J_FIN_WAIT:   n_state = S_L_DONE;
            S_L_DONE: begin
                if (is_rooted && !root_done) n_state = S_L_START;
                else if (r_in.mode == MODE_DIST && r_res != '0) n_state = S_D_RD;
                else n_state = S_OUT;
            end
            S_D_RD:         n_state = S_D_WAIT;
            S_D_WAIT:       n_state = (r_dcnt == 2'd2) ? S_D_CALC : S_D_RD;
            S_D_CALC:       n_state = S_OUT;
            S_OUT:          n_state = S_IDLE;
            default:        n_state = S_IDLE;
        endcase
    end

    // Memory ports.
    logic [NodeW-1:0] dnode;
    always_comb begin
        unique case (r_dcnt)
            2'd0:    dnode = r_in.node_a;
            2'd1:    dnode = r_in.node_b;
            default: dnode = r_res;
        endcase
    end

    logic [NodeW:0] dep_inc;
    assign dep_inc = {1'b0, dep_rdata} + 1'b1;

    always_comb begin
        anc_we    = 1'b0;
        dep_we    = 1'b0;
        anc_waddr = anc_addr(r_in.node_a, r_lvl);
        anc_wdata = '0;
        dep_waddr = slot_of(r_in.node_a);
        dep_wdata = '0;
        anc_raddr = anc_addr(r_x, r_lvl);
        dep_raddr = slot_of(r_in.node_b);
        unique case (r_state)
            S_ADD_WR_DEPTH: begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr(r_in.node_a, '0);
                anc_wdata = r_in.node_b;
                dep_we    = 1'b1;
                if (r_in.node_b == '0) dep_wdata = '0;
                else if (dep_inc[NodeW]) dep_wdata = DepthMax;
                else dep_wdata = dep_inc[NodeW-1:0];
            end
            S_ADD_RD_ANC: anc_raddr = anc_addr(r_x, r_lvl - 1'b1);
            S_ADD_WR_ANC: begin
                anc_we    = 1'b1;
                anc_wdata = (r_x == '0) ? '0 : anc_rdata;
            end
            S_L_RD_DA: dep_raddr = slot_of(wa);
            S_L_RD_DB: dep_raddr = slot_of(wb);
            S_J_RD_A:  anc_raddr = anc_addr(r_a, r_lvl);
            S_J_RD_B:  anc_raddr = anc_addr(r_b, r_lvl);
            S_J_FIN_RD: anc_raddr = anc_addr(r_a, '0);
            S_D_RD:    dep_raddr = slot_of(dnode);
            default: ;
        endcase
    end

    // Rooted combination of the three walk results (ur, rv, uv).
    logic [NodeW-1:0] root_pick;
    always_comb begin
        // r_l0 = uv, r_l1 = ur, final walk gives rv.
        if (r_l1 == r_res)      root_pick = r_l0;
        else if (r_res == r_l0) root_pick = r_l1;
        else if (r_l0 == r_l1)  root_pick = r_res;
        else                    root_pick = '0;
    end

    logic [NodeW-1:0] fin_a;
    assign fin_a = (r_x == '0) ? '0 : anc_rdata;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_in   <= i_item;
                r_walk <= '0;
                r_res  <= '0;
                r_dist <= '0;
                r_dcnt <= '0;
                r_lvl  <= '0;
                r_x    <= i_item.node_a;
                r_k    <= i_item.step_count;
                r_kth  <= (i_item.mode == MODE_KTH);
            end
            S_ADD_WR_DEPTH: begin
                r_x   <= r_in.node_b;
                r_lvl <= (LEVELS > 1) ? LvlW'(1) : '0;
            end
            S_ADD_WR_ANC: begin
                r_x   <= (r_x == '0) ? '0 : anc_rdata;
                r_lvl <= r_lvl + 1'b1;
            end
            S_L_START: begin
                r_res <= '0;
            end
            S_L_RD_DB: r_da <= dep_rdata;
            S_L_CMP: begin
                // Deeper node is climbed by the depth difference.
                r_lvl <= '0;
                if (r_da > dep_rdata) begin
                    r_a <= wb; r_x <= wa; r_k <= r_da - dep_rdata;
                end else begin
                    r_a <= wa; r_x <= wb; r_k <= dep_rdata - r_da;
                end
            end
            S_C_WAIT: begin
                r_k <= r_k >> 1;
                if (r_lvl == LvlLast) begin
                    // The climbed node ends the walk when it is none or meets the other node.
                    r_b <= c_node;
                    if (r_kth || c_node == '0 || c_node == r_a) r_res <= c_node;
                end else begin
                    r_x   <= c_step;
                    r_lvl <= r_lvl + 1'b1;
                end
            end
            S_J_RD_B: r_pa <= (r_a == '0) ? '0 : anc_rdata;
            S_J_WAIT: begin
                if (r_pa != '0 && r_pa != pb) begin
                    r_a <= r_pa;
                    r_b <= pb;
                end
                r_lvl <= r_lvl - 1'b1;
            end
            S_J_FIN_RD: r_x <= r_a;
            S_J_FIN_WAIT: begin
                // The answer is the parent of the lifted first node.
                r_res <= fin_a;
            end
            S_L_DONE: begin
                if (is_rooted) begin
                    unique case (r_walk)
                        2'd0:    r_l0 <= r_res;
                        2'd1:    r_l1 <= r_res;
                        default: r_res <= root_pick;
                    endcase
                    r_walk <= r_walk + 1'b1;
                end
                r_dsum <= '0;
            end
            S_D_WAIT: begin
                if (r_dcnt == 2'd2) begin
                    r_dsum <= r_dsum - (DistW+2)'({dep_rdata, 1'b0});
                end else begin
                    r_dsum <= r_dsum + (DistW+2)'(dep_rdata);
                end
                r_dcnt <= r_dcnt + 1'b1;
            end
            S_D_CALC: r_dist <= r_dsum[DistW+1] ? '0 : r_dsum[DistW-1:0];
            default: ;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
    always_comb begin
        o_item.result_node = r_res;
        o_item.distance    = r_dist;
        o_item.found       = (r_res != '0);
    end

    // A result beat only appears while the engine is busy.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat while idle");

    // Distance is zero outside distance mode.
    a_dist_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_in.mode != MODE_DIST) |-> (r_dist == '0))
        else $error("distance outside distance mode");

    // An add never reports a node.
    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_in.mode == MODE_ADD) |-> (r_res == '0))
        else $error("add produced a node");

    // The found flag follows the answer node.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_item.found == (o_item.result_node != '0)))
        else $error("found flag disagrees with the answer node");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bll_pkg::*;

    // Codes the package leaves unnamed: the unused modes.
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    localparam int unsigned RandItems  = 1300;
    localparam int unsigned CycleLimit = 1000000;

    // Predicts every answer of the engine from its own ancestor and depth tables.
    class lca_scoreboard;
        logic [NodeW-1:0] anc_tab [NodeCountDef][LevelsDef];
        logic [NodeW-1:0] depth_tab [NodeCountDef];
        t_out_item        answers_q[$];
        int               errors;

        function logic [NodeW-1:0] anc(logic [NodeW-1:0] n, int lvl);
            if (n == 0 || lvl >= LevelsDef) return '0;
            return anc_tab[n][lvl];
        endfunction

        function logic [NodeW-1:0] depth(logic [NodeW-1:0] n);
            if (n == 0) return '0;
            return depth_tab[n];
        endfunction

        function logic [NodeW-1:0] climb(logic [NodeW-1:0] n, logic [NodeW-1:0] k);
            for (int i = 0; i < LevelsDef; i++)
                if (k[i]) n = anc(n, i);
            return n;
        endfunction

        function logic [NodeW-1:0] lca(logic [NodeW-1:0] a, logic [NodeW-1:0] b);
            logic [NodeW-1:0] da, db, t, pa, pb;
            if (a == 0 || b == 0) return '0;
            da = depth(a);
            db = depth(b);
            if (da > db) begin
                t = a; a = b; b = t;
                t = da; da = db; db = t;
            end
            b = climb(b, db - da);
            if (b == 0) return '0;
            if (a == b) return a;
            for (int j = LevelsDef - 1; j >= 0; j--) begin
                pa = anc(a, j);
                pb = anc(b, j);
                if (pa != 0 && pa != pb) begin
                    a = pa;
                    b = pb;
                end
            end
            return anc(a, 0);
        endfunction

        // Works out the answer to one accepted beat and updates the tables.
        function void note_item(t_in_item it);
            t_out_item        r;
            logic [NodeW-1:0] ur, rv, uv;
            int               s;
            r = '0;
            case (it.mode)
                MODE_ADD: begin
                    if (it.node_a != 0) begin
                        anc_tab[it.node_a][0] = it.node_b;
                        if (it.node_b == 0) depth_tab[it.node_a] = '0;
                        else if (depth(it.node_b) == DepthMax) depth_tab[it.node_a] = DepthMax;
                        else depth_tab[it.node_a] = depth(it.node_b) + 1'b1;
                        for (int i = 1; i < LevelsDef; i++)
                            anc_tab[it.node_a][i] = anc(anc_tab[it.node_a][i-1], i - 1);
                    end
                end
                MODE_LCA: r.result_node = lca(it.node_a, it.node_b);
                MODE_KTH: r.result_node = climb(it.node_a, it.step_count);
                MODE_DIST: begin
                    r.result_node = lca(it.node_a, it.node_b);
                    if (r.result_node != 0) begin
                        s = int'(depth(it.node_a)) + int'(depth(it.node_b))
                            - 2 * int'(depth(r.result_node));
                        r.distance = (s > 0) ? DistW'(s) : '0;
                    end
                end
                MODE_ROOTED: begin
                    ur = lca(it.node_a, it.node_c);
                    rv = lca(it.node_c, it.node_b);
                    uv = lca(it.node_a, it.node_b);
                    if (ur == rv) r.result_node = uv;
                    else if (rv == uv) r.result_node = ur;
                    else if (uv == ur) r.result_node = rv;
                end
                default: ;
            endcase
            r.found = (r.result_node != 0);
            answers_q = {answers_q, r};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (answers_q.size() == 0) begin
                $error("result beat with no answer pending");
                errors++;
                return;
            end
            want = answers_q.pop_front();
            if (got.result_node !== want.result_node) begin
                $error("result_node expected %0d actual %0d", want.result_node, got.result_node);
                errors++;
            end
            if (got.distance !== want.distance) begin
                $error("distance expected %0d actual %0d", want.distance, got.distance);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found expected %0d actual %0d", want.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_done;
    t_out_item o_item;

    lca_scoreboard    sb = new();
    logic [NodeW-1:0] added_q[$];
    bit               is_added [NodeCountDef];
    int unsigned      cycles = 0;

    binary_lifting_lca_engine_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_item (i_item),
        .o_done (o_done),
        .o_item (o_item)
    );

    always #1 i_clk = ~i_clk;

    // Result monitor: each strobed beat is checked against the oldest answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_item);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] m, logic [NodeW-1:0] a,
                                           logic [NodeW-1:0] b, logic [NodeW-1:0] c,
                                           logic [NodeW-1:0] k);
        t_in_item it;
        it.mode       = m;
        it.node_a     = a;
        it.node_b     = b;
        it.node_c     = c;
        it.step_count = k;
        return it;
    endfunction

    function automatic logic [NodeW-1:0] any_added();
        return added_q[$urandom_range(0, added_q.size() - 1)];
    endfunction

    // Offers one beat after a random gap and holds it until busy is low.
    task automatic send(t_in_item it);
        int unsigned gap;
        gap = $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        // Busy only moves at rising edges, so its value here holds at the next one.
        while (busy) @(negedge i_clk);
        sb.note_item(it);
        if (it.mode == MODE_ADD && it.node_a != 0 && !is_added[it.node_a]) begin
            is_added[it.node_a] = 1'b1;
            added_q = {added_q, it.node_a};
        end
    endtask

    initial begin
        t_in_item         it;
        logic [NodeW-1:0] n;
        int unsigned      r;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: two trees, extreme ids, every mode and corner case.
        send(make_item(MODE_ADD, 10'd1023, 10'd0, 10'd0, 10'd1023));
        send(make_item(MODE_ADD, 10'd1, 10'd1023, 10'd1023, 10'd0));
        send(make_item(MODE_ADD, 10'd512, 10'd1, 10'd0, 10'd0));
        send(make_item(MODE_ADD, 10'd341, 10'd512, 10'd0, 10'd0));
        send(make_item(MODE_ADD, 10'd682, 10'd0, 10'd0, 10'd0));
        send(make_item(MODE_ADD, 10'd0, 10'd1, 10'd0, 10'd0));
        send(make_item(MODE_LCA, 10'd512, 10'd341, 10'd0, 10'd0));
        send(make_item(MODE_LCA, 10'd341, 10'd1023, 10'd0, 10'd0));
        send(make_item(MODE_LCA, 10'd341, 10'd682, 10'd0, 10'd0));
        send(make_item(MODE_LCA, 10'd1, 10'd0, 10'd0, 10'd0));
        send(make_item(MODE_LCA, 10'd1023, 10'd1023, 10'd0, 10'd0));
        send(make_item(MODE_KTH, 10'd341, 10'd0, 10'd0, 10'd0));
        send(make_item(MODE_KTH, 10'd341, 10'd0, 10'd0, 10'd3));
        send(make_item(MODE_KTH, 10'd341, 10'd0, 10'd0, 10'd4));
        send(make_item(MODE_KTH, 10'd341, 10'd0, 10'd0, 10'd1023));
        send(make_item(MODE_DIST, 10'd341, 10'd1, 10'd0, 10'd0));
        send(make_item(MODE_DIST, 10'd341, 10'd682, 10'd0, 10'd0));
        send(make_item(MODE_ROOTED, 10'd1023, 10'd341, 10'd512, 10'd0));
        send(make_item(MODE_ROOTED, 10'd341, 10'd1, 10'd682, 10'd0));
        send(make_item(MODE_RSVD5, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
        send(make_item(MODE_RSVD6, 10'd1, 10'd0, 10'd1, 10'd0));
        send(make_item(MODE_RSVD7, 10'd1023, 10'd1, 10'd1023, 10'd1023));

        // Random part: mostly growing the forest and querying added nodes.
        for (int i = 0; i < RandItems; i++) begin
            it = make_item(MODE_ADD, NodeW'($urandom), NodeW'($urandom),
                           NodeW'($urandom), NodeW'($urandom));
            r = $urandom_range(0, 99);
            if (r < 30 && added_q.size() < NodeCountDef - 1) begin
                do n = NodeW'($urandom_range(1, 1023)); while (is_added[n]);
                it.node_a = n;
                r = $urandom_range(0, 99);
                if (r < 10) it.node_b = '0;
                else if (r < 60) it.node_b = added_q[added_q.size() - 1];
                else it.node_b = any_added();
            end else if (r < 35) begin
                // Noise: an ignored add or an unused mode.
                if ($urandom_range(0, 1)) it.node_a = '0;
                else it.mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
            end else begin
                it.mode   = t_mode'($urandom_range(MODE_LCA, MODE_ROOTED));
                it.node_a = any_added();
                it.node_b = ($urandom_range(0, 9) == 0) ? '0 : any_added();
                it.node_c = any_added();
                if ($urandom_range(0, 1)) it.step_count = NodeW'($urandom_range(0, 40));
            end
            send(it);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain the answer queue, then wait before the final check.
        while (sb.answers_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.answers_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
